FILE: hdl/ils_pkg.sv
// Shared types and codes for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_INSERT     = 3'd3;
  localparam logic [2:0] CMD_REMOVE     = 3'd4;
  localparam logic [2:0] CMD_READ       = 3'd5;
  localparam logic [2:0] CMD_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [4:0]         position;
    logic signed [31:0] value_in;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         count_now;
    logic [1:0]         status;
  } res_t;

  // Broadcast to every cell: open a gap and load, or close a gap.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

FILE: hdl/ils_cell.sv
// One storage cell of the list: holds one element and shifts with its neighbors.
`timescale 1ns / 1ps

module ils_cell
  import ils_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PW  = 5
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [PW-1:0]       pos,
  input  logic signed [31:0]  lower,
  input  logic signed [31:0]  upper,
  output logic signed [31:0]  q
);

  localparam logic [PW-1:0] Idx = PW'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (Idx == pos) begin
        q <= ctl.value;
      end else if (Idx > pos) begin
        q <= lower;
      end
    end else if (ctl.rem && (Idx >= pos)) begin
      q <= upper;
    end
  end

endmodule

FILE: hdl/indexed_list_store.sv
// Top level of the indexed list store: command decode, count, cell chain and result register.
//
//   channel | valid     | stall     | payload  | moves
//   --------+-----------+-----------+----------+---------------------------------
//   command | cmd_valid | cmd_stall | cmd_item | command, position, value_in
//   result  | res_valid | res_stall | res_item | read_value, count_now, status
//
// An insert or remove moves all affected cells of the chain in parallel on
// the transfer edge; the result register is loaded on that same edge.
// A new command is taken in every cycle while the result side keeps up; the
// command side stalls only while a result is held by a stalled result side.
// Reset clears the count and the result valid; cell contents stay undefined.
`timescale 1ns / 1ps

module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd_item,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_item
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW   = (CNTW > 5) ? CNTW : 5;

  logic [CNTW-1:0]    count;
  logic [CNTW-1:0]    count_next;
  logic               accept;
  logic               full;
  logic [PW-1:0]      pos_w;
  logic [PW-1:0]      cnt_w;
  logic [PW-1:0]      cell_pos;
  logic [IW-1:0]      rd_idx;
  logic signed [31:0] rd_val;
  logic [1:0]         st;
  cell_ctl_t          ctl;
  logic signed [31:0] cell_q [CAPACITY];

  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = count >= CNTW'(CAPACITY);
  assign pos_w     = PW'(cmd_item.position);
  assign cnt_w     = PW'(count);
  assign rd_idx    = pos_w[IW-1:0];

  always_comb begin
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    ctl.value  = cmd_item.value_in;
    cell_pos   = pos_w;
    count_next = count;
    st         = ST_OK;
    rd_val     = '0;
    unique case (cmd_item.command)
      CMD_PUSH_BACK: begin
        cell_pos = cnt_w;
        if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        cell_pos = '0;
        if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        cell_pos = '0;
        if (count != '0) begin
          ctl.rem    = 1'b1;
          count_next = count - 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_w > cnt_w) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_w >= cnt_w) begin
          st = ST_RANGE;
        end else begin
          ctl.rem    = 1'b1;
          count_next = count - 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_w >= cnt_w) begin
          st = ST_RANGE;
        end else begin
          rd_val = cell_q[rd_idx];
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    // Nothing moves in the chain unless a command is actually transferred.
    if (!accept) begin
      ctl.ins = 1'b0;
      ctl.rem = 1'b0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    if (i == 0) begin : g_first
      assign lower = cell_q[i];
    end else begin : g_lower
      assign lower = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_q[i];
    end else begin : g_upper
      assign upper = cell_q[i+1];
    end
    ils_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (cell_pos),
      .lower (lower),
      .upper (upper),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_item.read_value <= rd_val;
      res_item.count_now  <= 5'(count_next);
      res_item.status     <= st;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(CAPACITY))
    else $error("element count above capacity");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && st == ST_FULL) |=> $stable(count))
    else $error("count changed on a dropped full command");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_item.command == CMD_CLEAR) |=> (count == '0))
    else $error("clear did not empty the list");

  a_result_reports_count: assert property (@(posedge clk) disable iff (rst)
    (accept) |=> (res_item.count_now == 5'(count)))
    else $error("reported count differs from stored count");

endmodule
